FILE: hdl/pmfb_pkg.sv
// shared types, command codes and defaults for the packed mono frame store
`default_nettype none
package pmfb_pkg;

  localparam int PANEL_WIDTH_DEF  = 168;
  localparam int PANEL_HEIGHT_DEF = 384;
  // widest store index over the whole parameter range (128 x 256 bytes)
  localparam int ADDR_MAX_W = 15;

  localparam logic [2:0] CMD_PIXEL = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_RECT  = 3'd2;
  localparam logic [2:0] CMD_IMAGE = 3'd3;
  localparam logic [2:0] CMD_RAW   = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  localparam logic [7:0] BYTE_ON  = 8'hFF;
  localparam logic [7:0] BYTE_OFF = 8'h00;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PIX,
    OP_FILL,
    OP_RECT,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [7:0]            data;
    logic [2:0]            bit_pos;
    logic                  on;
    logic [7:0]            nb;
    logic [8:0]            np;
    logic                  clip;
  } job_t;

endpackage
`default_nettype wire

FILE: hdl/pmfb_front.sv
// front end: takes requests, clips them and works out store addresses
`default_nettype none
module pmfb_front #(
  parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic [2:0]      cmd,
  input  wire logic [8:0]      pos_x,
  input  wire logic [8:0]      pos_y,
  input  wire logic [8:0]      rect_width,
  input  wire logic [8:0]      rect_height,
  input  wire logic            pixel_on,
  input  wire logic [7:0]      byte_value,
  input  wire logic [6:0]      src_block_col,
  input  wire logic [7:0]      src_pair_row,
  input  wire logic [12:0]     byte_index,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            q_full,
  input  wire logic            clearing,
  output logic                 q_push,
  output pmfb_pkg::job_t       job
);
  import pmfb_pkg::*;

  localparam int COLS  = PANEL_WIDTH / 4;
  localparam int PAIRS = PANEL_HEIGHT / 2;
  localparam int SIZE  = COLS * PAIRS;

  logic [6:0] bx;
  logic [7:0] by;
  logic [7:0] col_room;
  logic [8:0] pair_room;
  logic [7:0] nb;
  logic [8:0] np;
  logic [8:0] row;
  logic [7:0] col;
  logic [ADDR_MAX_W-1:0] tile_addr;
  logic pix_out;

  assign bx = pos_x[8:2];
  assign by = pos_y[8:1];

  always_comb begin
    col_room  = 8'(COLS) - {1'b0, bx};
    pair_room = 9'(PAIRS) - {1'b0, by};
    if ({1'b0, bx} >= 8'(COLS)) begin
      nb = '0;
    end else begin
      nb = ({1'b0, rect_width[8:2]} < col_room) ? {1'b0, rect_width[8:2]} : col_room;
    end
    if ({1'b0, by} >= 9'(PAIRS)) begin
      np = '0;
    end else begin
      np = ({1'b0, rect_height[8:1]} < pair_room) ? {1'b0, rect_height[8:1]} : pair_room;
    end
  end

  // one multiplier shared by pixel, rectangle and image addressing
  always_comb begin
    if (cmd == CMD_IMAGE) begin
      row = {1'b0, by} + {1'b0, src_pair_row};
      col = {1'b0, bx} + {1'b0, src_block_col};
    end else begin
      row = {1'b0, by};
      col = {1'b0, bx};
    end
    tile_addr = ADDR_MAX_W'(row) * ADDR_MAX_W'(COLS) + ADDR_MAX_W'(col);
  end

  assign pix_out = ({1'b0, pos_x} >= 10'(PANEL_WIDTH)) || ({1'b0, pos_y} >= 10'(PANEL_HEIGHT))
                   || ({1'b0, bx} >= 8'(COLS)) || ({1'b0, by} >= 9'(PAIRS));

  always_comb begin
    job         = '0;
    job.op      = OP_NONE;
    job.addr    = tile_addr;
    job.data    = byte_value;
    job.bit_pos = 3'd7 - {pos_x[1:0], pos_y[0]};
    job.on      = pixel_on;
    job.nb      = nb;
    job.np      = np;
    unique case (cmd)
      CMD_PIXEL: begin
        job.clip = pix_out;
        job.op   = pix_out ? OP_NONE : OP_PIX;
      end
      CMD_FILL: begin
        job.op = OP_FILL;
      end
      CMD_RECT: begin
        job.clip = (nb == '0) || (np == '0);
        job.op   = job.clip ? OP_NONE : OP_RECT;
        job.data = pixel_on ? BYTE_ON : BYTE_OFF;
      end
      CMD_IMAGE: begin
        job.clip = ({1'b0, src_block_col} >= nb) || ({1'b0, src_pair_row} >= np);
        job.op   = job.clip ? OP_NONE : OP_WRITE;
      end
      CMD_RAW, CMD_READ: begin
        job.addr = ADDR_MAX_W'(byte_index);
        job.clip = (16'(byte_index) >= 16'(SIZE));
        if (job.clip) begin
          job.op = OP_NONE;
        end else begin
          job.op = (cmd == CMD_RAW) ? OP_WRITE : OP_READ;
        end
      end
      default: begin
        job.op = OP_NONE;
      end
    endcase
  end

  // no request taken while the store is being cleared after reset
  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;

endmodule
`default_nettype wire

FILE: hdl/pmfb_queue.sv
// two-entry job queue between the front end and the store engine
`default_nettype none
module pmfb_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pmfb_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output pmfb_pkg::job_t      pop_job
);
  import pmfb_pkg::*;

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_job   = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        slots[wptr] <= push_job;
        wptr        <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pmfb_back.sv
// store engine: frame memory, read-modify-write, fill sweeps and result register
`default_nettype none
module pmfb_back #(
  parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire pmfb_pkg::job_t job,
  output logic                job_pop,
  output logic                clearing,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          read_data,
  output logic                clipped
);
  import pmfb_pkg::*;

  localparam int COLS  = PANEL_WIDTH / 4;
  localparam int PAIRS = PANEL_HEIGHT / 2;
  localparam int SIZE  = COLS * PAIRS;
  localparam int AW    = (SIZE > 1) ? $clog2(SIZE) : 1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RMW   = 6'b000100,
    ST_READ  = 6'b001000,
    ST_FILL  = 6'b010000,
    ST_RECT  = 6'b100000
  } state_t;

  logic [7:0] mem [SIZE];

  state_t      state;
  job_t        cur;
  logic [7:0]  rdata;
  logic [AW-1:0] sweep;
  logic [AW-1:0] row_base;
  logic [7:0]  col;
  logic [8:0]  row;
  logic [7:0]  mask;

  assign clearing = (state == ST_CLEAR);
  assign job_pop  = (state == ST_IDLE) && job_valid && !out_valid;
  assign mask     = 8'd1 << cur.bit_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          mem[sweep] <= BYTE_OFF;
          if (sweep == AW'(SIZE - 1)) begin
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        ST_IDLE: begin
          if (job_pop) begin
            cur <= job;
            unique case (job.op)
              OP_WRITE: begin
                mem[job.addr[AW-1:0]] <= job.data;
                out_valid <= 1'b1;
                read_data <= '0;
                clipped   <= 1'b0;
              end
              OP_READ: begin
                rdata <= mem[job.addr[AW-1:0]];
                state <= ST_READ;
              end
              OP_PIX: begin
                rdata <= mem[job.addr[AW-1:0]];
                state <= ST_RMW;
              end
              OP_FILL: begin
                sweep <= '0;
                state <= ST_FILL;
              end
              OP_RECT: begin
                row_base <= job.addr[AW-1:0];
                col      <= '0;
                row      <= '0;
                state    <= ST_RECT;
              end
              default: begin
                out_valid <= 1'b1;
                read_data <= '0;
                clipped   <= job.clip;
              end
            endcase
          end
        end
        ST_RMW: begin
          mem[cur.addr[AW-1:0]] <= cur.on ? (rdata | mask) : (rdata & ~mask);
          out_valid <= 1'b1;
          read_data <= '0;
          clipped   <= 1'b0;
          state     <= ST_IDLE;
        end
        ST_READ: begin
          out_valid <= 1'b1;
          read_data <= rdata;
          clipped   <= 1'b0;
          state     <= ST_IDLE;
        end
        ST_FILL: begin
          mem[sweep] <= cur.data;
          if (sweep == AW'(SIZE - 1)) begin
            out_valid <= 1'b1;
            read_data <= '0;
            clipped   <= 1'b0;
            state     <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        ST_RECT: begin
          mem[row_base + AW'(col)] <= cur.data;
          if (col == cur.nb - 8'd1) begin
            col <= '0;
            if (row == cur.np - 9'd1) begin
              out_valid <= 1'b1;
              read_data <= '0;
              clipped   <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              row      <= row + 9'd1;
              row_base <= row_base + AW'(COLS);
            end
          end else begin
            col <= col + 8'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/packed_mono_framebuffer_draw.sv
// top level of the packed monochrome frame store with drawing requests
// raw write, image byte and clipped requests finish in the idle state; pixel and read pass through RMW or READ
// fill all sweeps every store byte in turn, a rectangle each of its bytes, row by row
// one store port: one byte written or read per cycle, one request in the engine at a time
// a two-entry queue takes requests while the engine and the result register are busy
// after reset a clearing pass over every store byte holds in_ready low
`default_nettype none
module packed_mono_framebuffer_draw #(
  parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [8:0]  pos_x,
  input  wire logic [8:0]  pos_y,
  input  wire logic [8:0]  rect_width,
  input  wire logic [8:0]  rect_height,
  input  wire logic        pixel_on,
  input  wire logic [7:0]  byte_value,
  input  wire logic [6:0]  src_block_col,
  input  wire logic [7:0]  src_pair_row,
  input  wire logic [12:0] byte_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic             clipped
);
  import pmfb_pkg::*;

  job_t push_job;
  job_t pop_job;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic clearing;

  pmfb_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
    .cmd, .pos_x, .pos_y, .rect_width, .rect_height, .pixel_on, .byte_value,
    .src_block_col, .src_pair_row, .byte_index,
    .in_valid, .in_ready, .q_full, .clearing, .q_push, .job(push_job)
  );

  pmfb_queue u_queue (
    .clk, .rst, .push(q_push), .push_job, .full(q_full),
    .pop(q_pop), .pop_valid(q_valid), .pop_job
  );

  pmfb_back #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_back (
    .clk, .rst, .job_valid(q_valid), .job(pop_job), .job_pop(q_pop), .clearing,
    .out_valid, .out_ready, .read_data, .clipped
  );

endmodule
`default_nettype wire

FILE: hdl/pmfb_checker.sv
// port-level checks on the frame store top level, bound in below
`default_nettype none
module pmfb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic       clipped
);

  // clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken straight after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // a clipped request never returns read data
  a_clip_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> read_data == 8'd0)
    else $error("clipped result with nonzero read data");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(clipped))
    else $error("stalled result changed");

endmodule

bind packed_mono_framebuffer_draw pmfb_checker u_pmfb_checker (.*);
`default_nettype wire
